### rtl/alrp_pkg.sv
`default_nettype none
package alrp_pkg;

    localparam int MaxEntries = 16;
    localparam int SlotW      = $clog2(MaxEntries);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_BYTE  = 2'd2;

    localparam logic [1:0] KIND_GET   = 2'd0;
    localparam logic [1:0] KIND_MULTI = 2'd1;
    localparam logic [1:0] KIND_PAGE  = 2'd2;

    localparam logic [2:0] ST_ENTRY    = 3'd0;
    localparam logic [2:0] ST_FINISHED = 3'd1;
    localparam logic [2:0] ST_BELOW    = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_BADTYPE  = 3'd4;
    localparam logic [2:0] ST_OVERRUN  = 3'd5;
    localparam logic [2:0] ST_UNREQ    = 3'd6;

    localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] CFG_RECEIVED    = 2'd1;
    localparam logic [1:0] CFG_START       = 2'd2;

    localparam logic [3:0] LIST_PLAIN  = 4'h9;
    localparam logic [3:0] LIST_MULTI  = 4'hf;
    localparam logic [15:0] NOT_PRESENT = 16'hffff;
    localparam logic [4:0] ENTRY_HDR   = 5'd10;
    localparam logic [4:0] MULTI_HDR   = 5'd18;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot;
        logic [1:0]  kind;
        logic [31:0] attr_page;
        logic [31:0] attr_number;
        logic [15:0] max_len;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  out_slot;
        logic [63:0] object_id;
        logic [31:0] value_offset;
        logic [15:0] value_len;
        logic        present;
        logic [2:0]  status;
        logic        last;
    } out_item_t;

endpackage
`default_nettype wire

### rtl/alrp_ram.sv
`default_nettype none
module alrp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/attribute_list_response_parser.sv
// channel | dir | handshake      | payload
// in      | in  | in_valid/stall | alrp_pkg::in_item_t
// out     | out | out_valid/stall| alrp_pkg::out_item_t
// cfg     | in  | cfg_valid/ready| cfg_index, cfg_data
// Load and data beats are accepted directly; the last header byte of an entry walks
// the request table through the RAM read port, reading and then comparing each slot
// up to the matching one, or through every slot when none matches.
// A start walks the table the same way, up to the first page get.
// Each result waits in the output register; a second result of the same beat is
// held until the first drains. Input stalls during a walk and while a result waits.
// Reset idles the parser; table contents are undefined until loaded.
`default_nettype none
module attribute_list_response_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire alrp_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output alrp_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import alrp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LIST  = 5'b00010,
        S_ENTRY = 5'b00100,
        S_SKIP  = 5'b01000,
        S_WALK  = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        walk_start_reg, walk_start_next;
    logic [SlotW:0] widx_reg, widx_next;
    logic        wpend_reg, wpend_next;
    logic        any_get_reg, any_get_next, any_multi_reg, any_multi_next;
    logic [4:0]  ecount_reg;
    logic [31:0] rxlen_reg, rstart_reg;
    logic [31:0] remain_reg, remain_next, boff_reg, boff_next;
    logic [63:0] shift_reg, shift_next;
    logic [31:0] epage_reg, epage_next, enum_reg, enum_next;
    logic [15:0] elen_reg, elen_next, bcnt_reg, bcnt_next;
    logic        multi_reg, multi_next;
    logic [31:0] cur_reg, cur_next;
    out_item_t   obuf_reg, obuf_next, pend_reg, pend_next;
    logic        ovalid_reg, ovalid_next, pvalid_reg, pvalid_next;

    logic [63:0] ids_rd;
    logic [17:0] info_rd;
    logic        tbl_we;
    logic [SlotW-1:0] raddr;
    logic [SlotW:0] used;
    logic [4:0]  hdr;
    logic        accept, out_free;
    logic [31:0] avail;

    assign used = (ecount_reg > 5'(MaxEntries)) ? (SlotW+1)'(MaxEntries)
                                                : (SlotW+1)'(ecount_reg);
    assign hdr = multi_reg ? MULTI_HDR : ENTRY_HDR;
    assign avail = rxlen_reg - rstart_reg;
    assign out_free = !ovalid_reg || !out_stall;
    assign in_stall = (phase_reg == S_WALK) || wpend_reg || pvalid_reg || !out_free;
    assign accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign tbl_we = accept && in_data.command == CMD_LOAD
                    && {1'b0, in_data.slot} < 5'(MaxEntries);
    assign raddr = widx_next[SlotW-1:0];
    assign out_valid = ovalid_reg;
    assign out_data = obuf_reg;

    alrp_ram #(.Width(64), .Depth(MaxEntries)) u_ids (
        .clk(clk), .we(tbl_we), .waddr(in_data.slot[SlotW-1:0]),
        .wdata({in_data.attr_page, in_data.attr_number}),
        .raddr(raddr), .rdata(ids_rd));
    alrp_ram #(.Width(18), .Depth(MaxEntries)) u_info (
        .clk(clk), .we(tbl_we), .waddr(in_data.slot[SlotW-1:0]),
        .wdata({in_data.kind, in_data.max_len}),
        .raddr(raddr), .rdata(info_rd));

    function automatic out_item_t mk(input logic [3:0] s, input logic [63:0] o,
                                     input logic [31:0] off, input logic [15:0] l,
                                     input logic [2:0] st, input logic lst);
        out_item_t r;
        r.out_slot = s; r.object_id = o; r.value_offset = off; r.value_len = l;
        r.present = l != 16'd0; r.status = st; r.last = lst;
        return r;
    endfunction

    always_comb
    begin
        logic [15:0] item, usable;
        logic [31:0] rem2, skip, pos;
        logic [2:0]  pad;
        logic        emit1, emit2;
        out_item_t   r1, r2;
        phase_next = phase_reg; walk_start_next = walk_start_reg;
        widx_next = widx_reg; wpend_next = 1'b0;
        any_get_next = any_get_reg; any_multi_next = any_multi_reg;
        remain_next = remain_reg; boff_next = boff_reg; shift_next = shift_reg;
        epage_next = epage_reg; enum_next = enum_reg; elen_next = elen_reg;
        bcnt_next = bcnt_reg; multi_next = multi_reg; cur_next = cur_reg;
        obuf_next = obuf_reg; pend_next = pend_reg; pvalid_next = pvalid_reg;
        ovalid_next = ovalid_reg && out_stall;
        item = '0; usable = '0; rem2 = '0; skip = '0; pad = '0; pos = '0;
        emit1 = 1'b0; emit2 = 1'b0;
        r1 = '0; r2 = '0;
        if (pvalid_reg && out_free)
        begin
            obuf_next = pend_reg; ovalid_next = 1'b1; pvalid_next = 1'b0;
        end
        if (phase_reg == S_WALK)
        begin
            if (!wpend_reg && widx_reg != used)
            begin
                wpend_next = 1'b1;
            end
            else if (wpend_reg)
            begin
                if (walk_start_reg)
                begin
                    if (info_rd[17:16] == KIND_PAGE)
                    begin
                        usable = (avail < {16'd0, info_rd[15:0]}) ? avail[15:0]
                                                                   : info_rd[15:0];
                        r1 = mk(widx_reg[3:0], '0, '0, usable, ST_ENTRY, 1'b0);
                        r2 = mk('0, '0, '0, '0, ST_FINISHED, 1'b1);
                        emit1 = 1'b1; emit2 = 1'b1; phase_next = S_IDLE;
                    end
                    else
                    begin
                        any_get_next = any_get_reg || info_rd[17:16] == KIND_GET;
                        any_multi_next = any_multi_reg || info_rd[17:16] == KIND_MULTI;
                        widx_next = widx_reg + 1'b1;
                    end
                end
                else if (info_rd[17:16] <= KIND_MULTI && ids_rd == {epage_reg, enum_reg})
                begin
                    item = (elen_reg == NOT_PRESENT) ? 16'd0 : elen_reg;
                    usable = ({16'd0, item} > remain_reg) ? remain_reg[15:0] : item;
                    if (usable > info_rd[15:0])
                        usable = info_rd[15:0];
                    r1 = mk(widx_reg[3:0], multi_reg ? shift_reg : 64'd0,
                            cur_reg + 32'd1, usable, ST_ENTRY, 1'b0);
                    emit1 = 1'b1;
                    pad = 3'(4'd8 - 4'((5'd10 + 5'(item[2:0])) & 5'd7));
                    skip = {16'd0, item} + {29'd0, pad};
                    rem2 = remain_reg - skip;
                    if (skip >= remain_reg || rem2 < {27'd0, hdr})
                    begin
                        r2 = mk('0, '0, '0, '0, ST_FINISHED, 1'b1);
                        emit2 = 1'b1; phase_next = S_IDLE;
                    end
                    else
                    begin
                        remain_next = rem2; bcnt_next = skip[15:0]; phase_next = S_SKIP;
                    end
                end
                else
                begin
                    widx_next = widx_reg + 1'b1;
                end
            end
            else
            begin
                if (walk_start_reg)
                begin
                    if (!any_get_reg && !any_multi_reg)
                    begin
                        r1 = mk('0, '0, '0, '0, ST_FINISHED, 1'b1);
                        emit1 = 1'b1; phase_next = S_IDLE;
                    end
                    else if (avail < 32'd8)
                    begin
                        r1 = mk('0, '0, '0, '0, ST_SHORT, 1'b1);
                        emit1 = 1'b1; phase_next = S_IDLE;
                    end
                    else
                    begin
                        multi_next = any_multi_reg; remain_next = avail;
                        boff_next = '0; bcnt_next = '0; shift_next = '0;
                        phase_next = S_LIST;
                    end
                end
                else
                begin
                    r1 = mk('0, '0, '0, '0, ST_UNREQ, 1'b1);
                    emit1 = 1'b1; phase_next = S_IDLE;
                end
            end
        end
        else if (accept && in_data.command == CMD_START)
        begin
            if (rxlen_reg < rstart_reg)
            begin
                r1 = mk('0, '0, '0, '0, ST_BELOW, 1'b1);
                emit1 = 1'b1; phase_next = S_IDLE;
            end
            else
            begin
                phase_next = S_WALK; walk_start_next = 1'b1; widx_next = '0;
                any_get_next = 1'b0; any_multi_next = 1'b0;
            end
        end
        else if (accept && in_data.command == CMD_BYTE && phase_reg != S_IDLE)
        begin
            cur_next = boff_reg; boff_next = boff_reg + 32'd1;
            case (phase_reg)
                S_LIST:
                begin
                    if (bcnt_reg == 16'd0 && !((in_data.data_byte[3:0] == LIST_PLAIN && !multi_reg)
                        || (in_data.data_byte[3:0] == LIST_MULTI && multi_reg)))
                    begin
                        r1 = mk('0, '0, '0, '0, ST_BADTYPE, 1'b1);
                        emit1 = 1'b1; phase_next = S_IDLE;
                    end
                    else
                    begin
                        if (bcnt_reg >= 16'd4)
                            shift_next = {32'd0, shift_reg[23:0], in_data.data_byte};
                        if (bcnt_reg < 16'd7)
                            bcnt_next = bcnt_reg + 16'd1;
                        else if ({1'b0, shift_next[31:0]} + 33'd8 > {1'b0, remain_reg})
                        begin
                            r1 = mk('0, '0, '0, '0, ST_OVERRUN, 1'b1);
                            emit1 = 1'b1; phase_next = S_IDLE;
                        end
                        else
                        begin
                            remain_next = shift_next[31:0];
                            phase_next = S_ENTRY; bcnt_next = '0; shift_next = '0;
                            epage_next = '0; enum_next = '0; elen_next = '0;
                            if (remain_next < {27'd0, hdr})
                            begin
                                r1 = mk('0, '0, '0, '0, ST_FINISHED, 1'b1);
                                emit1 = 1'b1; phase_next = S_IDLE;
                            end
                        end
                    end
                end
                S_ENTRY:
                begin
                    pos = {16'd0, bcnt_reg} - (multi_reg ? 32'd8 : 32'd0);
                    if (multi_reg && bcnt_reg < 16'd8)
                        shift_next = {shift_reg[55:0], in_data.data_byte};
                    else if (pos < 32'd4)
                        epage_next = {epage_reg[23:0], in_data.data_byte};
                    else if (pos < 32'd8)
                        enum_next = {enum_reg[23:0], in_data.data_byte};
                    else
                        elen_next = {elen_reg[7:0], in_data.data_byte};
                    if (bcnt_reg + 16'd1 < {11'd0, hdr})
                        bcnt_next = bcnt_reg + 16'd1;
                    else
                    begin
                        remain_next = remain_reg - {27'd0, hdr};
                        phase_next = S_WALK; walk_start_next = 1'b0; widx_next = '0;
                    end
                end
                S_SKIP:
                begin
                    if (bcnt_reg <= 16'd1)
                    begin
                        phase_next = S_ENTRY; bcnt_next = '0; shift_next = '0;
                        epage_next = '0; enum_next = '0; elen_next = '0;
                    end
                    else
                        bcnt_next = bcnt_reg - 16'd1;
                end
                default:
                begin
                    phase_next = S_IDLE;
                end
            endcase
        end
        if (emit1)
        begin
            if (!ovalid_next)
            begin
                obuf_next = r1; ovalid_next = 1'b1;
                if (emit2)
                begin
                    pend_next = r2; pvalid_next = 1'b1;
                end
            end
            else
            begin
                pend_next = r1; pvalid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= S_IDLE; walk_start_reg <= 1'b0; widx_reg <= '0;
            wpend_reg <= 1'b0; any_get_reg <= 1'b0; any_multi_reg <= 1'b0;
            ecount_reg <= '0; rxlen_reg <= '0; rstart_reg <= '0;
            remain_reg <= '0; boff_reg <= '0; shift_reg <= '0;
            epage_reg <= '0; enum_reg <= '0; elen_reg <= '0; bcnt_reg <= '0;
            multi_reg <= 1'b0; ovalid_reg <= 1'b0; pvalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; walk_start_reg <= walk_start_next;
            widx_reg <= widx_next; wpend_reg <= wpend_next;
            any_get_reg <= any_get_next; any_multi_reg <= any_multi_next;
            remain_reg <= remain_next; boff_reg <= boff_next; shift_reg <= shift_next;
            epage_reg <= epage_next; enum_reg <= enum_next; elen_reg <= elen_next;
            bcnt_reg <= bcnt_next; multi_reg <= multi_next;
            ovalid_reg <= ovalid_next; pvalid_reg <= pvalid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ENTRY_COUNT: ecount_reg <= cfg_data[4:0];
                    CFG_RECEIVED:    rxlen_reg <= cfg_data;
                    CFG_START:       rstart_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next; obuf_reg <= obuf_next; pend_reg <= pend_next;
    end
endmodule
`default_nettype wire
